[rtl/assert_macros.svh]
// Assertion helpers for the perspective divide block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

[rtl/pdv_pkg.sv]
// ----------------------------------------------------------------------------
// pdv_pkg
// Shared types and constants of the perspective divide / viewport block.
// ----------------------------------------------------------------------------
package pdv_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_W = 64;   // dividend magnitude width, one cell per bit
	localparam int DVS_W = 32;   // divisor magnitude width
	localparam int LANES = 3;    // x, y, depth

	localparam logic [2:0] IDX_X_SCALE  = 3'd0;
	localparam logic [2:0] IDX_Y_SCALE  = 3'd1;
	localparam logic [2:0] IDX_D_SCALE  = 3'd2;
	localparam logic [2:0] IDX_D_OFFSET = 3'd3;
	localparam logic [2:0] IDX_WIDTH    = 3'd4;
	localparam logic [2:0] IDX_HEIGHT   = 3'd5;

	typedef struct packed {
		logic [LANES-1:0][DVS_W-1:0] rem;  // partial remainder
		logic [LANES-1:0][NUM_W-1:0] nq;   // dividend bits left, quotient bits in
		logic [DVS_W-1:0]            dvs;  // |w|
		logic [LANES-1:0]            neg;  // quotient sign
		logic                        zw;   // w is zero
	} div_t;

	function automatic logic [NUM_W-1:0] abs64(input logic signed [NUM_W-1:0] v);
		abs64 = v[NUM_W-1] ? NUM_W'(-v) : NUM_W'(v);
	endfunction

endpackage

[rtl/pdv_if.sv]
// ----------------------------------------------------------------------------
// pdv interfaces
// Vertex, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface pdv_vtx_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vertex_x;
	logic signed [31:0] vertex_y;
	logic signed [31:0] vertex_z;
	modport source (output valid, vertex_x, vertex_y, vertex_z, input ready);
	modport sink   (input valid, vertex_x, vertex_y, vertex_z, output ready);
endinterface

interface pdv_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] screen_x;
	logic signed [31:0] screen_y;
	logic signed [31:0] depth;
	logic               zero_w;
	logic               saturated;
	modport source (output valid, screen_x, screen_y, depth, zero_w, saturated,
		input ready);
	modport sink   (input valid, screen_x, screen_y, depth, zero_w, saturated,
		output ready);
endinterface

interface pdv_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[rtl/perspective_divide_viewport.sv]
// ----------------------------------------------------------------------------
// perspective_divide_viewport
// Perspective divide and viewport mapping, one vertex per cycle unless the
// result channel stalls. Stages: multiply, align, 64 divider cells (one
// quotient bit each), clamp, viewport multiply, output register. Throughput
// one beat per cycle while res.ready is high. Reset clears pipeline valids
// and loads the default configuration; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module perspective_divide_viewport
	import pdv_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	pdv_vtx_if.sink      vtx,
	pdv_res_if.source    res,
	pdv_cfg_if.sink      cfg
);

	localparam int MW  = 42;        // clamped x'/y' plus one
	localparam int PW  = MW + 15;   // viewport product
	localparam int NST = 5 + NUM_W; // pipeline stages
	localparam int S_DIV = 2;
	localparam int S_Q = S_DIV + NUM_W;
	localparam logic signed [MW-1:0] ONE = MW'(64'sd1 <<< FRAC_BITS);
	localparam logic [NUM_W-1:0] MID = NUM_W'(64'd1 << 40);

	logic signed [31:0] xs_q, ys_q, ds_q, doff_q;
	logic [13:0]        wid_q, hgt_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xs_q   <= 32'(ONE);
			ys_q   <= 32'(ONE);
			ds_q   <= -32'(ONE);
			doff_q <= '0;
			wid_q  <= 14'd640;
			hgt_q  <= 14'd480;
		end else if (cfg.valid) begin
			case (cfg.index)
				IDX_X_SCALE:  xs_q   <= cfg.data;
				IDX_Y_SCALE:  ys_q   <= cfg.data;
				IDX_D_SCALE:  ds_q   <= cfg.data;
				IDX_D_OFFSET: doff_q <= cfg.data;
				IDX_WIDTH:    wid_q  <= cfg.data[13:0];
				IDX_HEIGHT:   hgt_q  <= cfg.data[13:0];
				default: ;
			endcase
		end
	end

	// stage valids and a stall chain that lets bubbles collapse
	logic [NST-1:0] v_q;
	logic [NST:0]   adv;

	assign adv[NST] = res.ready;
	for (genvar k = 0; k < NST; k++) begin : g_adv
		assign adv[k] = !v_q[k] || adv[k+1];
	end
	assign vtx.ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0]) v_q[0] <= vtx.valid;
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	// s1: products
	logic signed [63:0] px_s1, py_s1, pd_s1;
	logic signed [31:0] vz_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			px_s1 <= 64'(vtx.vertex_x * 64'(xs_q));
			py_s1 <= 64'(vtx.vertex_y * 64'(ys_q));
			pd_s1 <= 64'(vtx.vertex_z * 64'(ds_q));
			vz_s1 <= vtx.vertex_z;
		end
	end

	// s2: depth numerator, magnitudes and signs
	div_t div_q [0:NUM_W];
	logic signed [63:0] numd;
	logic               wneg;

	assign numd = pd_s1 + (64'(doff_q) <<< FRAC_BITS);
	assign wneg = !vz_s1[31] && (vz_s1 != '0);   // w = -z negative

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			div_q[0].rem    <= '0;
			div_q[0].nq[0]  <= abs64(px_s1);
			div_q[0].nq[1]  <= abs64(py_s1);
			div_q[0].nq[2]  <= abs64(numd);
			div_q[0].neg[0] <= px_s1[63] ^ wneg;
			div_q[0].neg[1] <= py_s1[63] ^ wneg;
			div_q[0].neg[2] <= numd[63] ^ wneg;
			div_q[0].dvs    <= vz_s1[31] ? DVS_W'(-vz_s1) : DVS_W'(vz_s1);
			div_q[0].zw     <= (vz_s1 == '0);
		end
	end

	for (genvar k = 0; k < NUM_W; k++) begin : g_cell
		pdv_div_cell u_cell (
			.clk   (clk),
			.en    (adv[S_DIV + k]),
			.d_in  (div_q[k]),
			.d_out (div_q[k+1])
		);
	end

	// s3: signs, clamps, viewport offsets
	div_t dq;
	logic [NUM_W-1:0]   mx, my;
	logic signed [MW-1:0] xp, yp;
	logic signed [63:0] dzs;
	logic               dsat;
	logic signed [MW-1:0] xo_s3, yo_s3;
	logic signed [31:0] dz_s3;
	logic               dsat_s3, zw_s3;

	assign dq   = div_q[NUM_W];
	assign mx   = (dq.nq[0] > MID) ? MID : dq.nq[0];
	assign my   = (dq.nq[1] > MID) ? MID : dq.nq[1];
	assign xp   = dq.neg[0] ? -MW'(mx) : MW'(mx);
	assign yp   = dq.neg[1] ? -MW'(my) : MW'(my);
	assign dzs  = dq.neg[2] ? -64'(dq.nq[2]) : 64'(dq.nq[2]);
	assign dsat = dq.neg[2] ? (dq.nq[2] > 64'h8000_0000) : (dq.nq[2] > 64'h7FFF_FFFF);

	always_ff @(posedge clk) begin
		if (adv[S_Q]) begin
			xo_s3   <= xp + ONE;
			yo_s3   <= ONE - yp;
			dz_s3   <= dsat ? (dq.neg[2] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : dzs[31:0];
			dsat_s3 <= dsat;
			zw_s3   <= dq.zw;
		end
	end

	// s4: viewport multiply
	logic signed [PW-1:0] mx_s4, my_s4;
	logic signed [31:0]   dz_s4;
	logic                 dsat_s4, zw_s4;

	always_ff @(posedge clk) begin
		if (adv[S_Q + 1]) begin
			mx_s4   <= PW'(xo_s3 * $signed({1'b0, wid_q}));
			my_s4   <= PW'(yo_s3 * $signed({1'b0, hgt_q}));
			dz_s4   <= dz_s3;
			dsat_s4 <= dsat_s3;
			zw_s4   <= zw_s3;
		end
	end

	// s5: floor half, final clamp, output register
	logic signed [PW-1:0] hx, hy;
	logic                 hxs, hys;
	logic signed [31:0]   cx, cy;

	assign hx  = mx_s4 >>> 1;
	assign hy  = my_s4 >>> 1;
	assign hxs = (hx > PW'(64'sh7FFF_FFFF)) || (hx < PW'(-64'sh8000_0000));
	assign hys = (hy > PW'(64'sh7FFF_FFFF)) || (hy < PW'(-64'sh8000_0000));
	assign cx  = hxs ? (hx[PW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : hx[31:0];
	assign cy  = hys ? (hy[PW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : hy[31:0];

	always_ff @(posedge clk) begin
		if (adv[S_Q + 2]) begin
			res.screen_x  <= zw_s4 ? '0 : cx;
			res.screen_y  <= zw_s4 ? '0 : cy;
			res.depth     <= zw_s4 ? '0 : dz_s4;
			res.zero_w    <= zw_s4;
			res.saturated <= !zw_s4 && (hxs || hys || dsat_s4);
		end
	end

	assign res.valid = v_q[NST-1];

	`AST_NEXT(a_accept_fills, clk, arst_n, vtx.valid && vtx.ready, v_q[0])
	`AST_IMPL(a_stall_full, clk, arst_n, !vtx.ready, res.valid && !res.ready && (&v_q))
	`AST_IMPL(a_zero_w, clk, arst_n, res.valid && res.zero_w, !res.saturated && res.depth == '0)

endmodule

[rtl/pdv_div_cell.sv]
// ----------------------------------------------------------------------------
// pdv_div_cell
// One restoring-division step for all lanes, registered.
// ----------------------------------------------------------------------------
module pdv_div_cell
	import pdv_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  div_t d_in,
	output div_t d_out
);

	div_t nxt;

	always_comb begin
		logic [DVS_W:0] t;
		logic [DVS_W:0] diff;
		logic           ge;
		nxt = d_in;
		for (int l = 0; l < LANES; l++) begin
			t    = {d_in.rem[l], d_in.nq[l][NUM_W-1]};
			diff = t - {1'b0, d_in.dvs};
			ge   = (t >= {1'b0, d_in.dvs});
			nxt.rem[l] = ge ? diff[DVS_W-1:0] : t[DVS_W-1:0];
			nxt.nq[l]  = {d_in.nq[l][NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

[tb/perspective_divide_viewport_test.sv]
// ----------------------------------------------------------------------------
// perspective_divide_viewport_test
// Streams vertices through the perspective divide / viewport block under
// several configurations, with random gaps and stalls on both channels, and
// checks each result beat against a cycle-free model of the arithmetic.
// ----------------------------------------------------------------------------
module perspective_divide_viewport_test;
	import pdv_pkg::*;

	localparam longint ONE_Q   = longint'(1) << FRAC_BITS_DEF;
	localparam longint DIV_MAX = longint'(1) << 40;
	localparam longint S32_HI  = 64'sd2147483647;
	localparam longint S32_LO  = -64'sd2147483648;
	localparam int     DRAIN   = 80;
	localparam int     LIMIT   = 2000000;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vertex_t;

	typedef struct {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] dz;
		logic               zw;
		logic               sat;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pdv_vtx_if vtx();
	pdv_res_if res();
	pdv_cfg_if cfg();

	perspective_divide_viewport DUT (
		.clk(clk), .arst_n(arst_n), .vtx(vtx), .res(res), .cfg(cfg)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the configuration registers
	longint x_sc = ONE_Q, y_sc = ONE_Q, d_sc = -ONE_Q, d_off = 0;
	longint width = 640, height = 480;

	vertex_t vtx_pending[$];
	pixel_t  pixels_due[$];
	bit      failed = 1'b0;
	bit      idle_on = 1'b1;
	bit      vtx_hold = 1'b0;
	int      stall_req = 0, stall_seen = 0, stall_left = 0;
	int      cycles = 0;

	function automatic longint sat32(longint v, ref bit flag);
		if (v > S32_HI) begin flag = 1'b1; return S32_HI; end
		if (v < S32_LO) begin flag = 1'b1; return S32_LO; end
		return v;
	endfunction

	function automatic pixel_t project(vertex_t v);
		pixel_t p;
		longint vx, vy, vz, w, xp, yp, dz;
		bit s;
		vx = v.x; vy = v.y; vz = v.z;
		s = 1'b0;
		p = '{0, 0, 0, 1'b1, 1'b0};
		if (vz == 0)
			return p;
		w = -vz;
		xp = (vx * x_sc) / w;
		yp = (vy * y_sc) / w;
		dz = (d_sc * vz + d_off * ONE_Q) / w;
		if (xp > DIV_MAX) xp = DIV_MAX;
		if (xp < -DIV_MAX) xp = -DIV_MAX;
		if (yp > DIV_MAX) yp = DIV_MAX;
		if (yp < -DIV_MAX) yp = -DIV_MAX;
		// halving floors toward minus infinity
		p.sx = 32'(sat32(((xp + ONE_Q) * width) >>> 1, s));
		p.sy = 32'(sat32(((ONE_Q - yp) * height) >>> 1, s));
		p.dz = 32'(sat32(dz, s));
		p.zw = 1'b0;
		p.sat = s;
		return p;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// vertex acceptance: queue expected results, track configuration writes
	always @(posedge clk) begin
		vtx_hold = vtx.valid && !vtx.ready;
		if (vtx.valid && vtx.ready) begin
			pixels_due.push_back(project(vtx_pending.pop_front()));
		end
		if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				IDX_X_SCALE:  x_sc  = longint'(signed'(cfg.data));
				IDX_Y_SCALE:  y_sc  = longint'(signed'(cfg.data));
				IDX_D_SCALE:  d_sc  = longint'(signed'(cfg.data));
				IDX_D_OFFSET: d_off = longint'(signed'(cfg.data));
				IDX_WIDTH:    width  = longint'(cfg.data[13:0]);
				IDX_HEIGHT:   height = longint'(cfg.data[13:0]);
				default: ;
			endcase
		end
	end

	// an offered beat stays put until it is taken
	always @(negedge clk) begin
		if (vtx_hold) begin
			vtx.valid <= 1'b1;
		end else if (arst_n && vtx_pending.size() > 0 &&
				!(idle_on && $urandom_range(99) < 28)) begin
			vtx.valid <= 1'b1;
			vtx.vertex_x <= vtx_pending[0].x;
			vtx.vertex_y <= vtx_pending[0].y;
			vtx.vertex_z <= vtx_pending[0].z;
		end else begin
			vtx.valid <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		pixel_t e;
		if (res.valid && res.ready) begin
			if (pixels_due.size() == 0) begin
				$display("%0t: result beat with nothing expected", $time);
				failed = 1'b1;
			end else begin
				e = pixels_due.pop_front();
				if (res.screen_x !== e.sx || res.screen_y !== e.sy ||
						res.depth !== e.dz || res.zero_w !== e.zw ||
						res.saturated !== e.sat) begin
					$display("%0t: mismatch exp x=%h y=%h d=%h zw=%b sat=%b",
						$time, e.sx, e.sy, e.dz, e.zw, e.sat);
					$display("%0t:          got x=%h y=%h d=%h zw=%b sat=%b",
						$time, res.screen_x, res.screen_y, res.depth,
						res.zero_w, res.saturated);
					failed = 1'b1;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (stall_req != stall_seen) begin
			stall_seen <= stall_req;
			stall_left <= 400;
			res.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= !(idle_on && $urandom_range(99) < 28);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		forever begin
			@(posedge clk);
			if (cfg.ready) break;
		end
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(3) - 1;
			3, 4, 5: return $urandom_range(32'h3_0000) - 32'h1_8000;
			default: return $urandom;
		endcase
	endfunction

	function automatic vertex_t rnd_vertex();
		vertex_t v;
		v.x = rnd_word();
		v.y = rnd_word();
		case ($urandom_range(9))
			0: v.z = 0;
			1: v.z = rnd_word();
			2: v.z = $urandom;
			default: v.z = -$urandom_range(32'h40_0000, 1);
		endcase
		return v;
	endfunction

	task automatic run_batch(int n);
		repeat (n) vtx_pending.push_back(rnd_vertex());
		wait (vtx_pending.size() == 0 && pixels_due.size() == 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_all(logic [31:0] xs, logic [31:0] ys, logic [31:0] ds,
			logic [31:0] dof, logic [31:0] w, logic [31:0] h);
		write_reg(IDX_X_SCALE, xs);
		write_reg(IDX_Y_SCALE, ys);
		write_reg(IDX_D_SCALE, ds);
		write_reg(IDX_D_OFFSET, dof);
		write_reg(IDX_WIDTH, w);
		write_reg(IDX_HEIGHT, h);
	endtask

	initial begin
		logic signed [31:0] ext[6];
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, zero w, corners of the view
		ext = '{32'sh7FFFFFFF, -32'sh80000000, 0, 1, -1, 32'sh10000};
		for (int i = 0; i < 6; i++)
			vtx_pending.push_back('{ext[i], ext[5 - i], ext[i]});
		vtx_pending.push_back('{32'sh10000, 32'sh10000, -32'sh10000});
		vtx_pending.push_back('{-32'sh10000, -32'sh10000, -32'sh10000});
		vtx_pending.push_back('{32'sh7FFFFFFF, -32'sh80000000, 32'sh1});
		vtx_pending.push_back('{-32'sh80000000, 32'sh7FFFFFFF, -32'sh1});
		vtx_pending.push_back('{5, 7, 0});
		vtx_pending.push_back('{32'sh8000, 32'sh8000, -32'sh20000});
		vtx_pending.push_back('{-3, 3, -32'sh80000000});
		vtx_pending.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF});
		run_batch(140);

		// long receiver stall while vertices keep coming
		stall_req = stall_req + 1;
		run_batch(140);

		set_all($urandom, $urandom, $urandom, $urandom,
			$urandom_range(8192, 1), $urandom_range(8192, 1));
		write_reg(3'd6, $urandom);
		write_reg(3'd7, $urandom);
		idle_on = 1'b0;
		run_batch(150);
		idle_on = 1'b1;

		set_all(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			8192, 1);
		run_batch(130);

		set_all(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			14'h3FFF, 0);
		vtx_pending.push_back('{32'sh7FFFFFFF, -32'sh80000000, -32'sh1});
		vtx_pending.push_back('{-32'sh80000000, 32'sh7FFFFFFF, 32'sh1});
		run_batch(130);

		set_all(32'h18000, 32'h14000, 32'hFFFE_8000, 32'hFFFF_0000, 1, 8192);
		stall_req = stall_req + 1;
		run_batch(130);

		set_all(32'h10000, 32'h10000, 32'hFFFF0000, 0, 640, 480);
		run_batch(260);

		repeat (DRAIN) @(posedge clk);
		if (!failed && pixels_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
